// ----- rtl/alrs_pkg.sv -----
`default_nettype none
package alrs_pkg;

	localparam int TRACKED_BYTES = 28;
	localparam int SLOT_COUNT    = 1024;
	localparam int REC_BYTES     = TRACKED_BYTES + 12;
	localparam int BANK_DEPTH    = 2 * TRACKED_BYTES;
	localparam int BANK_AW       = $clog2(BANK_DEPTH);

	localparam logic [31:0] MAGIC_WORD = 32'h424F_4F54;
	localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
	localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
	localparam logic [31:0] INTEG_WORD = 32'h494E_5447;
	localparam logic [7:0]  ERASED_VAL = 8'hFF;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_BYTE  = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ERASED = 2'd0,
		KIND_VALID  = 2'd1,
		KIND_BAD    = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
		logic [5:0] read_index;
	} req_t;

	typedef struct packed {
		logic [9:0] slot_index;
		logic [1:0] slot_kind;
		logic       valid_seen;
		logic [9:0] latest_slot;
		logic       integrity_enabled;
		logic       free_seen;
		logic [9:0] free_slot;
		logic       scan_done;
		logic [7:0] read_byte;
	} rsp_t;

	// result of one word before the bank read data joins it
	typedef struct packed {
		logic [9:0] slot_index;
		logic [1:0] slot_kind;
		logic       valid_seen;
		logic [9:0] latest_slot;
		logic       integrity_enabled;
		logic       free_seen;
		logic [9:0] free_slot;
		logic       scan_done;
		logic       rd_ok;
	} res_t;

	typedef struct packed {
		logic               wr_en;
		logic [BANK_AW-1:0] wr_addr;
		logic [7:0]         wr_data;
		logic               rd_en;
		logic [BANK_AW-1:0] rd_addr;
	} bank_req_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic logic [31:0] shift_in(input logic [31:0] w, input logic [7:0] b);
		return {b, w[31:8]};
	endfunction

	// byte idx of bank sel in the flat payload store
	function automatic logic [BANK_AW-1:0] bank_addr(input logic sel, input logic [5:0] idx);
		logic [6:0] a;
		a = sel ? ({1'b0, idx} + 7'(TRACKED_BYTES)) : {1'b0, idx};
		return a[BANK_AW-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/append_log_record_scanner_core.sv -----
// Reads and slot-ending bytes give a result, registered in stage 2 from stage 1.
// Throughput: one input word per cycle unless req_stall; the CRC byte update,
// slot classification and payload bank write all act on the input register.
// Reset (arst_n low) clears scan state, flags, the bank select and both pipeline
// valids; the payload bank is not cleared; read data is used only once written.
`default_nettype none
module append_log_record_scanner_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  wire alrs_pkg::req_t req,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output alrs_pkg::rsp_t      rsp
);
	import alrs_pkg::*;

	logic      s1_valid_q;
	req_t      req_s1;
	logic      s2_valid_q;
	res_t      res_s2;
	logic      en;
	logic      adv;
	res_t      res;
	logic      res_ok;
	bank_req_t bank;
	logic [7:0] rd_data;

	// stage 2 moves when empty or taken; stage 1 may still fill behind a stall
	assign en        = !s2_valid_q || !rsp_stall;
	assign req_stall = s1_valid_q && !en;
	assign adv       = s1_valid_q && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (!req_stall) begin
				s1_valid_q <= req_valid;
			end
			if (en) begin
				s2_valid_q <= adv && res_ok;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	alrs_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (req_s1),
		.res    (res),
		.res_ok (res_ok),
		.bank   (bank)
	);

	alrs_bank u_bank (
		.clk     (clk),
		.bank    (bank),
		.rd_data (rd_data)
	);

	assign rsp_valid = s2_valid_q;

	always_comb begin
		rsp.slot_index        = res_s2.slot_index;
		rsp.slot_kind         = res_s2.slot_kind;
		rsp.valid_seen        = res_s2.valid_seen;
		rsp.latest_slot       = res_s2.latest_slot;
		rsp.integrity_enabled = res_s2.integrity_enabled;
		rsp.free_seen         = res_s2.free_seen;
		rsp.free_slot         = res_s2.free_slot;
		rsp.scan_done         = res_s2.scan_done;
		rsp.read_byte         = res_s2.rd_ok ? rd_data : 8'd0;
	end

endmodule
`default_nettype wire

// ----- rtl/alrs_bank.sv -----
`default_nettype none
module alrs_bank (
	input  wire                      clk,
	input  wire alrs_pkg::bank_req_t bank,
	output logic [7:0]               rd_data
);
	import alrs_pkg::*;

	logic [7:0] mem [BANK_DEPTH];

	always_ff @(posedge clk) begin
		if (bank.wr_en) begin
			mem[bank.wr_addr] <= bank.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (bank.rd_en) begin
			rd_data <= mem[bank.rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/alrs_scan.sv -----
`default_nettype none
module alrs_scan (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 adv,
	input  wire alrs_pkg::req_t item,
	output alrs_pkg::res_t      res,
	output logic                res_ok,
	output alrs_pkg::bank_req_t bank
);
	import alrs_pkg::*;

	logic [5:0]  pos_q, pos_nx;
	logic [31:0] crc_q, crc_nx;
	logic [31:0] magic_q, magic_nx;
	logic [31:0] integ_q, integ_nx;
	logic [31:0] stored_q, stored_nx;
	logic        erased_q, erased_nx;
	logic        latest_bank_q, latest_bank_nx;
	logic [9:0]  slot_q, slot_nx;
	logic [9:0]  latest_slot_q, latest_slot_nx;
	logic [9:0]  free_slot_q, free_slot_nx;
	logic        f_valid_q, f_valid_nx;
	logic        f_integ_q, f_integ_nx;
	logic        f_free_q, f_free_nx;
	logic        f_done_q, f_done_nx;
	logic [5:0]  pay_idx;
	logic [10:0] slot_inc;

	always_comb begin
		pos_nx         = pos_q;
		crc_nx         = crc_q;
		magic_nx       = magic_q;
		integ_nx       = integ_q;
		stored_nx      = stored_q;
		erased_nx      = erased_q;
		latest_bank_nx = latest_bank_q;
		slot_nx        = slot_q;
		latest_slot_nx = latest_slot_q;
		free_slot_nx   = free_slot_q;
		f_valid_nx     = f_valid_q;
		f_integ_nx     = f_integ_q;
		f_free_nx      = f_free_q;
		f_done_nx      = f_done_q;
		res_ok         = 1'b0;
		res            = '0;
		bank           = '0;
		pay_idx        = pos_q - 6'd4;
		slot_inc       = {1'b0, slot_q} + 11'd1;

		case (item.cmd)
			CMD_START: begin
				pos_nx         = '0;
				crc_nx         = ALL_ONES;
				magic_nx       = '0;
				integ_nx       = '0;
				stored_nx      = '0;
				erased_nx      = 1'b1;
				slot_nx        = '0;
				latest_slot_nx = '0;
				free_slot_nx   = '0;
				f_valid_nx     = 1'b0;
				f_integ_nx     = 1'b0;
				f_free_nx      = 1'b0;
				f_done_nx      = 1'b0;
			end
			CMD_READ: begin
				res_ok        = 1'b1;
				res.rd_ok     = f_valid_q && ({1'b0, item.read_index} < 7'(TRACKED_BYTES));
				bank.rd_en    = adv;
				bank.rd_addr  = res.rd_ok ? bank_addr(latest_bank_q, item.read_index) : '0;
			end
			CMD_BYTE: begin
				if (!f_done_q) begin
					if (item.data_byte != ERASED_VAL) begin
						erased_nx = 1'b0;
					end
					if ({1'b0, pos_q} < 7'd4) begin
						magic_nx = shift_in(magic_q, item.data_byte);
					end else if ({1'b0, pos_q} < 7'(TRACKED_BYTES + 8)) begin
						crc_nx = crc_byte(crc_q, item.data_byte);
						if ({1'b0, pos_q} < 7'(TRACKED_BYTES + 4)) begin
							bank.wr_en   = adv;
							bank.wr_addr = bank_addr(!latest_bank_q, pay_idx);
							bank.wr_data = item.data_byte;
						end else begin
							integ_nx = shift_in(integ_q, item.data_byte);
						end
					end else begin
						stored_nx = shift_in(stored_q, item.data_byte);
					end

					if ({1'b0, pos_q} + 7'd1 < 7'(REC_BYTES)) begin
						pos_nx = pos_q + 6'd1;
					end else begin
						// last byte of the slot: classify
						res_ok         = 1'b1;
						res.slot_index = slot_q;
						if (erased_nx) begin
							res.slot_kind = KIND_ERASED;
							f_free_nx     = 1'b1;
							f_done_nx     = 1'b1;
							free_slot_nx  = slot_q;
						end else if (magic_nx == MAGIC_WORD && (crc_nx ^ ALL_ONES) == stored_nx) begin
							res.slot_kind  = KIND_VALID;
							latest_bank_nx = !latest_bank_q;
							latest_slot_nx = slot_q;
							f_valid_nx     = 1'b1;
							f_integ_nx     = (integ_nx == INTEG_WORD);
						end else begin
							res.slot_kind = KIND_BAD;
						end
						if (slot_inc >= 11'(SLOT_COUNT)) begin
							f_done_nx = 1'b1;
						end
						slot_nx   = slot_inc[9:0];
						pos_nx    = '0;
						crc_nx    = ALL_ONES;
						magic_nx  = '0;
						integ_nx  = '0;
						stored_nx = '0;
						erased_nx = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		// status shows flags after this word (unchanged for a read)
		res.valid_seen        = f_valid_nx;
		res.latest_slot       = latest_slot_nx;
		res.integrity_enabled = f_integ_nx;
		res.free_seen         = f_free_nx;
		res.free_slot         = free_slot_nx;
		res.scan_done         = f_done_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			crc_q         <= ALL_ONES;
			magic_q       <= '0;
			integ_q       <= '0;
			stored_q      <= '0;
			erased_q      <= 1'b1;
			latest_bank_q <= 1'b0;
			slot_q        <= '0;
			latest_slot_q <= '0;
			free_slot_q   <= '0;
			f_valid_q     <= 1'b0;
			f_integ_q     <= 1'b0;
			f_free_q      <= 1'b0;
			f_done_q      <= 1'b0;
		end else if (adv) begin
			pos_q         <= pos_nx;
			crc_q         <= crc_nx;
			magic_q       <= magic_nx;
			integ_q       <= integ_nx;
			stored_q      <= stored_nx;
			erased_q      <= erased_nx;
			latest_bank_q <= latest_bank_nx;
			slot_q        <= slot_nx;
			latest_slot_q <= latest_slot_nx;
			free_slot_q   <= free_slot_nx;
			f_valid_q     <= f_valid_nx;
			f_integ_q     <= f_integ_nx;
			f_free_q      <= f_free_nx;
			f_done_q      <= f_done_nx;
		end
	end

endmodule
`default_nettype wire
